@@ hdl/ssba_pkg.sv @@
// Shared types and constants for the swap slot bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ssba_pkg;

    // Field widths of the stream words
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Bitmap word width
    localparam int BITS_PER_WORD = 32;
    localparam int BIT_SEL_W     = 5;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_FIND    = 2'd0,
        MODE_MARK    = 2'd1,
        MODE_RELEASE = 2'd2
    } mode_t;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SAME = 2'd1,
        STATUS_NONE = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_BIT,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    in_ready;     // request port open
        logic    req_load;     // capture request word
        logic    addr_rst;     // scan address back to word 0
        logic    addr_inc;     // advance scan address
        logic    clr_wr;       // write zero word at scan address
        logic    rd_en;        // read bitmap word
        logic    rd_slot;      // read address from request slot, else scan address
        logic    bit_wr;       // write request word with slot bit flipped
        logic    stage_load;   // load result staging register
        status_t stage_status; // status to stage
        logic    stage_found;  // stage found slot, else zero
        logic    out_load;     // move staged result to output register
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        mode_t mode;       // registered request mode
        logic  slot_oob;   // request slot beyond the bitmap
        logic  bit_set;    // slot bit in the word just read
        logic  word_full;  // word just read has no free bit
        logic  chk_last;   // word just read is the last one
        logic  found_oob;  // lowest free bit lies beyond the slot count
        logic  scan_last;  // scan address is the last word
        logic  out_free;   // output register can take a result
    } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/ssba_ctrl.sv @@
// Controller state machine for the swap slot bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

module ssba_ctrl
    import ssba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.stage_status = STATUS_OK;

        unique case (state_reg)
            // sweep zeros through the bitmap after reset
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.addr_rst = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end

            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    cmd.addr_rst = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_FIND:
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.addr_inc = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    MODE_MARK, MODE_RELEASE:
                    begin
                        if (sts.slot_oob)
                        begin
                            cmd.stage_load   = 1'b1;
                            cmd.stage_status = STATUS_SAME;
                            state_next       = ST_RESP;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_slot = 1'b1;
                            state_next  = ST_BIT;
                        end
                    end
                    default:
                    begin
                        // unused mode: plain ok
                        cmd.stage_load   = 1'b1;
                        cmd.stage_status = STATUS_OK;
                        state_next       = ST_RESP;
                    end
                endcase
            end

            // slot word is in the read register: test and flip the bit
            ST_BIT:
            begin
                cmd.stage_load = 1'b1;
                cmd.rd_slot    = 1'b1;
                state_next     = ST_RESP;
                if ((sts.mode == MODE_MARK) == sts.bit_set)
                begin
                    cmd.stage_status = STATUS_SAME;
                end
                else
                begin
                    cmd.bit_wr       = 1'b1;
                    cmd.stage_status = STATUS_OK;
                end
            end

            // one word checked per cycle while the next one is read
            ST_SCAN:
            begin
                if (!sts.word_full)
                begin
                    cmd.stage_load = 1'b1;
                    state_next     = ST_RESP;
                    if (sts.found_oob)
                    begin
                        cmd.stage_status = STATUS_NONE;
                    end
                    else
                    begin
                        cmd.stage_status = STATUS_OK;
                        cmd.stage_found  = 1'b1;
                    end
                end
                else if (sts.chk_last)
                begin
                    cmd.stage_load   = 1'b1;
                    cmd.stage_status = STATUS_NONE;
                    state_next       = ST_RESP;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_inc = 1'b1;
                end
            end

            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ssba_datapath.sv @@
// Bitmap memory, scan address, request and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ssba_datapath
    import ssba_pkg::*;
#(
    parameter int NUM_SLOTS = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctl_cmd_t               cmd,
    output dp_sts_t                     sts,
    input  wire logic [IN_TDATA_W-1:0]  in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OUT_TDATA_W-1:0]      out_data
);

    localparam int WORD_COUNT = (NUM_SLOTS + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int FW = AW + BIT_SEL_W;
    localparam logic [AW-1:0] LAST_WORD  = AW'(WORD_COUNT - 1);
    localparam logic [FW:0]   SLOT_LIMIT = (FW + 1)'(NUM_SLOTS);

    // lowest clear bit of a word
    function automatic logic [BIT_SEL_W-1:0] first_zero(input logic [BITS_PER_WORD-1:0] w);
        logic [BIT_SEL_W-1:0] pos;
        pos = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = BIT_SEL_W'(i);
            end
        end
        return pos;
    endfunction

    logic [BITS_PER_WORD-1:0] mem [WORD_COUNT];
    logic [BITS_PER_WORD-1:0] rd_data_reg;
    logic [AW-1:0]            chk_addr_reg;
    logic [AW-1:0]            scan_addr_reg;
    mode_t                    mode_reg;
    logic [SLOT_W-1:0]        slot_reg;
    status_t                  stage_status_reg;
    logic [SLOT_W-1:0]        stage_slot_reg;
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [SLOT_W-1:0]        out_slot_reg;

    logic [AW+SLOT_W-1:0]     slot_ext;
    logic [AW-1:0]            slot_word;
    logic [BIT_SEL_W-1:0]     slot_bit;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [BITS_PER_WORD-1:0] wr_data;
    logic                     wr_en;
    logic [FW-1:0]            found;
    logic [FW+SLOT_W-1:0]     found_ext;
    logic [BITS_PER_WORD-1:0] slot_onehot;

    // request slot split into word and bit
    assign slot_ext    = {{AW{1'b0}}, slot_reg};
    assign slot_word   = slot_ext[AW+BIT_SEL_W-1:BIT_SEL_W];
    assign slot_bit    = slot_reg[BIT_SEL_W-1:0];
    assign slot_onehot = BITS_PER_WORD'(1) << slot_bit;

    // memory address and write data selection
    assign rd_addr = cmd.rd_slot ? slot_word : scan_addr_reg;
    assign wr_addr = cmd.bit_wr ? slot_word : scan_addr_reg;
    assign wr_data = cmd.bit_wr ? (rd_data_reg ^ slot_onehot) : '0;
    assign wr_en   = cmd.bit_wr | cmd.clr_wr;

    // found slot from checked word
    assign found     = {chk_addr_reg, first_zero(rd_data_reg)};
    assign found_ext = {{SLOT_W{1'b0}}, found};

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            chk_addr_reg <= rd_addr;
        end
    end

    // request and staging payload
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            mode_reg <= mode_t'(in_data[MODE_W-1:0]);
            slot_reg <= in_data[MODE_W+SLOT_W-1:MODE_W];
        end
        if (cmd.stage_load)
        begin
            stage_status_reg <= cmd.stage_status;
            stage_slot_reg   <= cmd.stage_found ? found_ext[SLOT_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= stage_status_reg;
            out_slot_reg   <= stage_slot_reg;
        end
    end

    // scan address counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.addr_rst)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.addr_inc)
            begin
                scan_addr_reg <= scan_addr_reg + AW'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status towards the controller
    always_comb
    begin
        sts.mode      = mode_reg;
        sts.slot_oob  = {{(32 - SLOT_W){1'b0}}, slot_reg} >= 32'(NUM_SLOTS);
        sts.bit_set   = rd_data_reg[slot_bit];
        sts.word_full = &rd_data_reg;
        sts.chk_last  = chk_addr_reg == LAST_WORD;
        sts.found_oob = {1'b0, found} >= SLOT_LIMIT;
        sts.scan_last = scan_addr_reg == LAST_WORD;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_TDATA_W - STATUS_W - SLOT_W){1'b0}}, out_slot_reg, out_status_reg};

endmodule

`default_nettype wire

@@ hdl/swap_slot_bitmap_allocator_core.sv @@
// Top level of the swap slot bitmap allocator.
//
//  channel  dir  width  fields (low bit first)
//  s_axis   in   16     mode[1:0], slot_index[11:2]
//  m_axis   out  16     status[1:0], found_slot[11:2]
//
// Find reads and checks one bitmap word per cycle through the single memory
// read port. Mark and release read the slot word, test the bit and write it
// back flipped when it changes, then hand off the result; when the slot is out
// of range, or for an unused mode, the read and write-back are skipped. After
// reset a clearing pass zeroes all NUM_SLOTS/32 (rounded up) bitmap words,
// with s_axis_tready low. A result waits in the output register while m_axis is
// stalled; the next request is taken meanwhile and its result held back.
`timescale 1ns / 1ps
`default_nettype none

module swap_slot_bitmap_allocator_core
    import ssba_pkg::*;
#(
    parameter int NUM_SLOTS = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[1:0], slot_index[11:2]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // status[1:0], found_slot[11:2]
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // controller
    ssba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    ssba_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

`default_nettype wire
